// ===== rtl/kdtk_pkg.sv =====
// Shared constants and register codes for the k-nearest-neighbor selection block.
// Used by the front end, the candidate queue, the slot engine and the top level.
package kdtk_pkg;

    localparam int INDEX_BITS    = 20;
    localparam int NC_BITS       = 4;
    localparam int APB_ADDR_BITS = 4;
    localparam int APB_DATA_BITS = 32;
    localparam int QUEUE_DEPTH   = 4;

    localparam logic [NC_BITS-1:0] NC_RESET = 4'd3;

    typedef enum logic [1:0] {
        REG_QUERY_X        = 2'd0,
        REG_QUERY_Y        = 2'd1,
        REG_NEIGHBOR_COUNT = 2'd2
    } t_reg_idx;

endpackage

// ===== rtl/kdtk_front.sv =====
// Front end: accepts candidate points and computes the saturated squared distance
// to the query point in a two-stage pipeline. Depends on kdtk_pkg.
module kdtk_front #(
    parameter int COORD_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [COORD_BITS-1:0]        i_point_x,
    input  logic signed [COORD_BITS-1:0]        i_point_y,
    input  logic [kdtk_pkg::INDEX_BITS-1:0]     i_point_index,
    input  logic                                i_last,
    input  logic [COORD_BITS-1:0]               i_query_x,
    input  logic [COORD_BITS-1:0]               i_query_y,
    input  logic                                i_full,
    output logic                                o_push,
    output logic [2*COORD_BITS:0]               o_dist,
    output logic [kdtk_pkg::INDEX_BITS-1:0]     o_index,
    output logic                                o_last
);
    localparam int DIFF_BITS = COORD_BITS + 1;
    localparam int SQ_BITS   = 2 * COORD_BITS;
    localparam int DIST_BITS = 2 * COORD_BITS + 1;
    localparam logic [DIST_BITS-1:0] DIST_INF = '1;

    logic                                r_v1;
    logic                                r_v2;
    logic signed [DIFF_BITS-1:0]         r_dx;
    logic signed [DIFF_BITS-1:0]         r_dy;
    logic [kdtk_pkg::INDEX_BITS-1:0]     r_idx1;
    logic [kdtk_pkg::INDEX_BITS-1:0]     r_idx2;
    logic                                r_last1;
    logic                                r_last2;
    logic [SQ_BITS-1:0]                  r_sqx;
    logic [SQ_BITS-1:0]                  r_sqy;
    logic                                w_stall;
    logic signed [2*DIFF_BITS-1:0]       w_prod_x;
    logic signed [2*DIFF_BITS-1:0]       w_prod_y;
    logic [DIST_BITS-1:0]                w_sum;

    assign w_stall  = r_v2 && i_full;
    assign o_ready  = !w_stall;
    assign w_prod_x = r_dx * r_dx;
    assign w_prod_y = r_dy * r_dy;
    assign w_sum    = {1'b0, r_sqx} + {1'b0, r_sqy};
    assign o_dist   = (w_sum == DIST_INF) ? (DIST_INF - DIST_BITS'(1)) : w_sum;
    assign o_index  = r_idx2;
    assign o_last   = r_last2;
    assign o_push   = r_v2 && !i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (!w_stall) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!w_stall) begin
            r_dx    <= {i_point_x[COORD_BITS-1], i_point_x}
                     - {i_query_x[COORD_BITS-1], i_query_x};
            r_dy    <= {i_point_y[COORD_BITS-1], i_point_y}
                     - {i_query_y[COORD_BITS-1], i_query_y};
            r_idx1  <= i_point_index;
            r_last1 <= i_last;
            r_sqx   <= w_prod_x[SQ_BITS-1:0];
            r_sqy   <= w_prod_y[SQ_BITS-1:0];
            r_idx2  <= r_idx1;
            r_last2 <= r_last1;
        end
    end

endmodule

// ===== rtl/kdtk_fifo.sv =====
// Short candidate queue between the distance front end and the slot engine.
// Depth comes from kdtk_pkg; entries are held in flip-flops.
module kdtk_fifo #(
    parameter int WIDTH = 54
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty,
    output logic             o_full
);
    import kdtk_pkg::*;

    localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0]    r_mem [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] r_wr;
    logic [PTR_BITS-1:0] r_rd;
    logic [CNT_BITS-1:0] r_count;

    assign o_data  = r_mem[r_rd];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CNT_BITS'(QUEUE_DEPTH));

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + PTR_BITS'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + PTR_BITS'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + CNT_BITS'(1);
                2'b01:   r_count <= r_count - CNT_BITS'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("Candidate queue written while full.");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("Candidate queue read while empty.");

endmodule

// ===== rtl/kdtk_back.sv =====
// Slot engine: scans the kept slots for the farthest one, replaces it with a closer
// candidate, and on the last candidate emits the active slots and clears all slots. Depends on kdtk_pkg.
module kdtk_back #(
    parameter int MAX_NEIGHBORS = 8,
    parameter int COORD_BITS    = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_q_empty,
    output logic                                o_q_pop,
    input  logic [2*COORD_BITS:0]               i_dist,
    input  logic [kdtk_pkg::INDEX_BITS-1:0]     i_index,
    input  logic                                i_last,
    input  logic [kdtk_pkg::NC_BITS-1:0]        i_neighbor_count,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [kdtk_pkg::INDEX_BITS-1:0]     o_neighbor_index,
    output logic [2*COORD_BITS:0]               o_neighbor_distance_sq,
    output logic                                o_neighbor_valid,
    output logic                                o_last_result
);
    import kdtk_pkg::*;

    localparam int DIST_BITS = 2 * COORD_BITS + 1;
    localparam int SLOT_BITS = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
    localparam int K_BITS    = $clog2(MAX_NEIGHBORS + 1);
    localparam int CMP_BITS  = (K_BITS > NC_BITS) ? K_BITS : NC_BITS;
    localparam logic [DIST_BITS-1:0] DIST_INF = '1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_UPDATE,
        S_EMIT
    } t_state;

    t_state                   r_state;
    logic [DIST_BITS-1:0]     r_dist [MAX_NEIGHBORS];
    logic [INDEX_BITS-1:0]    r_idx  [MAX_NEIGHBORS];
    logic [MAX_NEIGHBORS-1:0] r_valid;
    logic [DIST_BITS-1:0]     r_cand_dist;
    logic [INDEX_BITS-1:0]    r_cand_index;
    logic                     r_cand_last;
    logic [K_BITS-1:0]        r_k;
    logic [SLOT_BITS-1:0]     r_scan;
    logic [DIST_BITS-1:0]     r_far_dist;
    logic [SLOT_BITS-1:0]     r_far_slot;
    logic                     r_out_valid;
    logic [INDEX_BITS-1:0]    r_out_index;
    logic [DIST_BITS-1:0]     r_out_dist;
    logic                     r_out_nv;
    logic                     r_out_last;

    logic [CMP_BITS-1:0]      w_nc;
    logic [K_BITS-1:0]        w_k;
    logic [DIST_BITS-1:0]     w_rd_dist;
    logic                     w_scan_last;
    logic                     w_out_free;

    always_comb begin
        w_nc = CMP_BITS'(i_neighbor_count);
        if (w_nc == '0) begin
            w_k = K_BITS'(1);
        end else if (w_nc > CMP_BITS'(MAX_NEIGHBORS)) begin
            w_k = K_BITS'(MAX_NEIGHBORS);
        end else begin
            w_k = w_nc[K_BITS-1:0];
        end
    end

    assign w_rd_dist   = r_valid[r_scan] ? r_dist[r_scan] : DIST_INF;
    assign w_scan_last = (K_BITS'(r_scan) == (r_k - K_BITS'(1)));
    assign w_out_free  = !r_out_valid || i_ready;
    assign o_q_pop     = (r_state == S_IDLE) && !i_q_empty;

    assign o_valid                = r_out_valid;
    assign o_neighbor_index       = r_out_index;
    assign o_neighbor_distance_sq = r_out_dist;
    assign o_neighbor_valid       = r_out_nv;
    assign o_last_result          = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_EMIT && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (!i_q_empty) begin
                        r_cand_dist  <= i_dist;
                        r_cand_index <= i_index;
                        r_cand_last  <= i_last;
                        r_k          <= w_k;
                        r_scan       <= '0;
                        r_state      <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_scan == '0 || w_rd_dist > r_far_dist) begin
                        r_far_dist <= w_rd_dist;
                        r_far_slot <= r_scan;
                    end
                    if (w_scan_last) begin
                        r_state <= S_UPDATE;
                    end else begin
                        r_scan <= r_scan + SLOT_BITS'(1);
                    end
                end
                S_UPDATE: begin
                    if (r_cand_dist < r_far_dist) begin
                        r_dist[r_far_slot]  <= r_cand_dist;
                        r_idx[r_far_slot]   <= r_cand_index;
                        r_valid[r_far_slot] <= 1'b1;
                    end
                    r_scan  <= '0;
                    r_state <= r_cand_last ? S_EMIT : S_IDLE;
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_out_index <= r_valid[r_scan] ? r_idx[r_scan] : '0;
                        r_out_dist  <= w_rd_dist;
                        r_out_nv    <= r_valid[r_scan];
                        r_out_last  <= w_scan_last;
                        if (w_scan_last) begin
                            r_valid <= '0;
                            r_state <= S_IDLE;
                        end else begin
                            r_scan <= r_scan + SLOT_BITS'(1);
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN || r_state == S_EMIT) |-> (K_BITS'(r_scan) < r_k))
        else $error("Slot pointer beyond the active neighbor count.");

    a_clear_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && w_out_free && w_scan_last)
        |=> (r_valid == '0 && r_out_valid && r_out_last && r_state == S_IDLE))
        else $error("Slots not cleared after the final result was issued.");

    a_pop_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |=> (r_state == S_SCAN && r_scan == '0))
        else $error("Candidate taken from the queue without starting a scan.");

endmodule

// ===== rtl/knn_distance_top_k_core.sv =====
// Top level of the k-nearest-neighbor selection block: APB register file, distance
// front end, candidate queue and slot engine. Depends on kdtk_pkg and the kdtk_* modules.
//
// The block keeps the k points closest to a query point set over APB (query_x at 0x0,
// query_y at 0x4, neighbor_count at 0x8; a count of 0 acts as 1 and one above
// MAX_NEIGHBORS acts as MAX_NEIGHBORS). Candidates enter on the slave stream at up to
// one per cycle, while the queue is not full, into a two-stage distance pipeline and a
// four-entry queue. The slot engine then takes each candidate from the queue, scans the
// slots for the farthest one (one slot per cycle), and replaces that slot if the candidate
// is strictly closer. After a candidate marked with tlast, the engine issues k results, one
// slot per cycle in slot order while the master stream accepts, flags empty slots as not
// valid with an all-ones distance, marks the final one with tlast, and clears all slots.
// The engine takes no new candidate from the queue until it is through with the last one.
module knn_distance_top_k_core #(
    parameter int MAX_NEIGHBORS = 8,
    parameter int COORD_BITS    = 16,
    localparam int S_TDATA_BITS = ((2 * COORD_BITS + kdtk_pkg::INDEX_BITS + 7) / 8) * 8,
    localparam int M_TDATA_BITS = ((2 * COORD_BITS + 1 + kdtk_pkg::INDEX_BITS + 7) / 8) * 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // APB configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [kdtk_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  logic [kdtk_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [kdtk_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                                pready,
    // Candidate stream
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [S_TDATA_BITS-1:0]             i_s_tdata,  // point_x, point_y, point_index
    input  logic                                i_s_tlast,  // last_candidate
    // Neighbor stream
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [M_TDATA_BITS-1:0]             o_m_tdata,  // neighbor_index, neighbor_distance_sq
    output logic                                o_m_tuser,  // neighbor_valid
    output logic                                o_m_tlast   // last_result
);
    import kdtk_pkg::*;

    localparam int DIST_BITS = 2 * COORD_BITS + 1;
    localparam int Q_BITS    = DIST_BITS + INDEX_BITS + 1;

    logic [COORD_BITS-1:0]  r_query_x;
    logic [COORD_BITS-1:0]  r_query_y;
    logic [NC_BITS-1:0]     r_neighbor_count;

    logic                   w_wr;
    t_reg_idx               w_reg;
    logic                   w_push;
    logic                   w_pop;
    logic                   w_full;
    logic                   w_empty;
    logic [DIST_BITS-1:0]   w_f_dist;
    logic [INDEX_BITS-1:0]  w_f_index;
    logic                   w_f_last;
    logic [Q_BITS-1:0]      w_q_in;
    logic [Q_BITS-1:0]      w_q_out;
    logic [INDEX_BITS-1:0]  w_nb_index;
    logic [DIST_BITS-1:0]   w_nb_dist;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;
    assign w_reg  = t_reg_idx'(paddr[APB_ADDR_BITS-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_query_x        <= '0;
            r_query_y        <= '0;
            r_neighbor_count <= NC_RESET;
        end else if (w_wr) begin
            unique case (w_reg)
                REG_QUERY_X:        r_query_x        <= pwdata[COORD_BITS-1:0];
                REG_QUERY_Y:        r_query_y        <= pwdata[COORD_BITS-1:0];
                REG_NEIGHBOR_COUNT: r_neighbor_count <= pwdata[NC_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg)
            REG_QUERY_X:        prdata = APB_DATA_BITS'(r_query_x);
            REG_QUERY_Y:        prdata = APB_DATA_BITS'(r_query_y);
            REG_NEIGHBOR_COUNT: prdata = APB_DATA_BITS'(r_neighbor_count);
            default:            prdata = '0;
        endcase
    end

    kdtk_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_s_tvalid),
        .o_ready       (o_s_tready),
        .i_point_x     (i_s_tdata[COORD_BITS-1:0]),
        .i_point_y     (i_s_tdata[2*COORD_BITS-1:COORD_BITS]),
        .i_point_index (i_s_tdata[2*COORD_BITS+INDEX_BITS-1:2*COORD_BITS]),
        .i_last        (i_s_tlast),
        .i_query_x     (r_query_x),
        .i_query_y     (r_query_y),
        .i_full        (w_full),
        .o_push        (w_push),
        .o_dist        (w_f_dist),
        .o_index       (w_f_index),
        .o_last        (w_f_last)
    );

    assign w_q_in = {w_f_last, w_f_index, w_f_dist};

    kdtk_fifo #(
        .WIDTH (Q_BITS)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_q_in),
        .i_pop   (w_pop),
        .o_data  (w_q_out),
        .o_empty (w_empty),
        .o_full  (w_full)
    );

    kdtk_back #(
        .MAX_NEIGHBORS (MAX_NEIGHBORS),
        .COORD_BITS    (COORD_BITS)
    ) u_back (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_q_empty              (w_empty),
        .o_q_pop                (w_pop),
        .i_dist                 (w_q_out[DIST_BITS-1:0]),
        .i_index                (w_q_out[DIST_BITS+INDEX_BITS-1:DIST_BITS]),
        .i_last                 (w_q_out[Q_BITS-1]),
        .i_neighbor_count       (r_neighbor_count),
        .o_valid                (o_m_tvalid),
        .i_ready                (i_m_tready),
        .o_neighbor_index       (w_nb_index),
        .o_neighbor_distance_sq (w_nb_dist),
        .o_neighbor_valid       (o_m_tuser),
        .o_last_result          (o_m_tlast)
    );

    assign o_m_tdata = M_TDATA_BITS'({w_nb_dist, w_nb_index});

endmodule

// ===== verif/knn_distance_top_k_checker.sv =====
`timescale 1ns / 100ps
// Checker for knn_distance_top_k_core: watches the APB port and both streams, keeps its own
// copy of the query registers and the neighbor slots, and compares every neighbor transfer.
// Depends on kdtk_pkg for the register codes and bus widths.
module knn_distance_top_k_checker
    import kdtk_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_psel,
    input  logic                     i_penable,
    input  logic                     i_pwrite,
    input  logic [APB_ADDR_BITS-1:0] i_paddr,
    input  logic [APB_DATA_BITS-1:0] i_pwdata,
    input  logic [APB_DATA_BITS-1:0] i_prdata,
    input  logic                     i_pready,
    input  logic                     i_s_tvalid,
    input  logic                     i_s_tready,
    input  logic [55:0]              i_s_tdata,  // point_x, point_y, point_index
    input  logic                     i_s_tlast,  // last_candidate
    input  logic                     i_m_tvalid,
    input  logic                     i_m_tready,
    input  logic [55:0]              i_m_tdata,  // neighbor_index, neighbor_distance_sq
    input  logic                     i_m_tuser,  // neighbor_valid
    input  logic                     i_m_tlast,  // last_result
    output int                       o_pending,
    output int                       o_fails
);

    localparam int MAX_K = 8;
    localparam logic [32:0] DIST_INF = '1;

    typedef struct packed {
        logic [19:0] index;
        logic [32:0] dist_sq;
        logic        valid;
        logic        last;
    } t_neighbor;

    t_neighbor         expected_neighbors[$];
    logic signed [15:0] query_x;
    logic signed [15:0] query_y;
    logic [3:0]        neighbor_count;
    logic [32:0]       slot_dist[MAX_K];
    logic [19:0]       slot_index[MAX_K];
    logic              slot_valid[MAX_K];
    int                fail_count = 0;
    int                pending_q = 0;

    assign o_pending = pending_q;
    assign o_fails   = fail_count;

    function void clear_slots();
        for (int i = 0; i < MAX_K; i++) begin
            slot_dist[i]  = DIST_INF;
            slot_index[i] = '0;
            slot_valid[i] = 1'b0;
        end
    endfunction

    function automatic int active_k();
        if (neighbor_count == 0) return 1;
        if (neighbor_count > MAX_K) return MAX_K;
        return int'(neighbor_count);
    endfunction

    function automatic logic [32:0] dist_to_query(logic signed [15:0] px, logic signed [15:0] py);
        logic signed [16:0] dx;
        logic signed [16:0] dy;
        logic [16:0]        ax;
        logic [16:0]        ay;
        logic [33:0]        sum;
        dx  = px - query_x;
        dy  = py - query_y;
        ax  = (dx < 0) ? -dx : dx;
        ay  = (dy < 0) ? -dy : dy;
        sum = 34'(ax) * 34'(ax) + 34'(ay) * 34'(ay);
        if (sum >= 34'(DIST_INF)) return DIST_INF - 1;
        return sum[32:0];
    endfunction

    task automatic place_candidate(logic [15:0] px, logic [15:0] py, logic [19:0] idx,
                                   logic last);
        int          k;
        int          far_slot;
        logic [32:0] d;
        logic [32:0] far_dist;
        t_neighbor   n;
        k        = active_k();
        d        = dist_to_query(px, py);
        far_slot = 0;
        far_dist = slot_dist[0];
        for (int i = 1; i < k; i++) begin
            if (slot_dist[i] > far_dist) begin
                far_dist = slot_dist[i];
                far_slot = i;
            end
        end
        if (d < far_dist) begin
            slot_dist[far_slot]  = d;
            slot_index[far_slot] = idx;
            slot_valid[far_slot] = 1'b1;
        end
        if (last) begin
            for (int i = 0; i < k; i++) begin
                n.index   = slot_valid[i] ? slot_index[i] : '0;
                n.dist_sq = slot_valid[i] ? slot_dist[i] : DIST_INF;
                n.valid   = slot_valid[i];
                n.last    = (i == k - 1);
                expected_neighbors.push_back(n);
            end
            clear_slots();
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_neighbor   want;
        logic [31:0] reg_mask;
        logic [31:0] reg_value;
        if (!i_rst_n) begin
            query_x        = '0;
            query_y        = '0;
            neighbor_count = NC_RESET;
            clear_slots();
            expected_neighbors.delete();
        end else begin
            if (i_psel && i_penable && i_pready) begin
                if (i_pwrite) begin
                    case (t_reg_idx'(i_paddr[3:2]))
                        REG_QUERY_X:        query_x = i_pwdata[15:0];
                        REG_QUERY_Y:        query_y = i_pwdata[15:0];
                        REG_NEIGHBOR_COUNT: neighbor_count = i_pwdata[3:0];
                        default: ;
                    endcase
                end else begin
                    reg_mask = '0;
                    case (t_reg_idx'(i_paddr[3:2]))
                        REG_QUERY_X: begin
                            reg_mask  = 32'h0000_FFFF;
                            reg_value = {16'h0, query_x};
                        end
                        REG_QUERY_Y: begin
                            reg_mask  = 32'h0000_FFFF;
                            reg_value = {16'h0, query_y};
                        end
                        REG_NEIGHBOR_COUNT: begin
                            reg_mask  = 32'h0000_000F;
                            reg_value = {28'h0, neighbor_count};
                        end
                        default: ;
                    endcase
                    if (reg_mask != 0 && (i_prdata & reg_mask) !== reg_value) begin
                        $error("prdata: expected %0h, actual %0h", reg_value,
                               i_prdata & reg_mask);
                        fail_count++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                place_candidate(i_s_tdata[15:0], i_s_tdata[31:16], i_s_tdata[51:32],
                                i_s_tlast);
            end
            if (i_m_tvalid && i_m_tready) begin
                if (expected_neighbors.size() == 0) begin
                    $error("unexpected neighbor transfer: index %0h", i_m_tdata[19:0]);
                    fail_count++;
                end else begin
                    want = expected_neighbors.pop_front();
                    if (i_m_tdata[19:0] !== want.index) begin
                        $error("neighbor_index: expected %0h, actual %0h", want.index,
                               i_m_tdata[19:0]);
                        fail_count++;
                    end
                    if (i_m_tdata[52:20] !== want.dist_sq) begin
                        $error("neighbor_distance_sq: expected %0h, actual %0h",
                               want.dist_sq, i_m_tdata[52:20]);
                        fail_count++;
                    end
                    if (i_m_tuser !== want.valid) begin
                        $error("neighbor_valid: expected %0b, actual %0b", want.valid,
                               i_m_tuser);
                        fail_count++;
                    end
                    if (i_m_tlast !== want.last) begin
                        $error("last_result: expected %0b, actual %0b", want.last,
                               i_m_tlast);
                        fail_count++;
                    end
                end
            end
        end
        pending_q <= expected_neighbors.size();
    end

endmodule

// ===== verif/knn_distance_top_k_core_tb.sv =====
`timescale 1ns / 100ps
// Top of the knn_distance_top_k_core testbench: clock, reset, APB set-up of the query, and
// candidate queries with random burst gaps and output stalls; the checker decides the verdict.
// Depends on kdtk_pkg, knn_distance_top_k_core and knn_distance_top_k_checker.
module knn_distance_top_k_core_tb;
    import kdtk_pkg::*;

    localparam int                     CYCLE_LIMIT = 400000;
    localparam int                     SETTLE      = 120;
    localparam int                     RANDOM_PTS  = 430;
    localparam logic [APB_ADDR_BITS-1:0] UNUSED_ADDR = 4'hC;

    logic                     i_clk      = 1'b0;
    logic                     i_rst_n    = 1'b0;
    logic                     psel       = 1'b0;
    logic                     penable    = 1'b0;
    logic                     pwrite     = 1'b0;
    logic [APB_ADDR_BITS-1:0] paddr      = '0;
    logic [APB_DATA_BITS-1:0] pwdata     = '0;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;
    logic                     i_s_tvalid = 1'b0;
    logic                     o_s_tready;
    logic [55:0]              i_s_tdata  = '0;
    logic                     i_s_tlast  = 1'b0;
    logic                     o_m_tvalid;
    logic                     i_m_tready = 1'b0;
    logic [55:0]              o_m_tdata;
    logic                     o_m_tuser;
    logic                     o_m_tlast;

    int pending;
    int fail_count;
    int cycle_count = 0;
    int burst_left  = 0;
    int stall_mode  = 0;
    int stall_tick  = 0;

    knn_distance_top_k_core uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    knn_distance_top_k_checker neighbor_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_psel     (psel),
        .i_penable  (penable),
        .i_pwrite   (pwrite),
        .i_paddr    (paddr),
        .i_pwdata   (pwdata),
        .i_prdata   (prdata),
        .i_pready   (pready),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .i_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_m_tdata  (o_m_tdata),
        .i_m_tuser  (o_m_tuser),
        .i_m_tlast  (o_m_tlast),
        .o_pending  (pending),
        .o_fails    (fail_count)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("knn_distance_top_k_core_tb failed");
            $finish;
        end
    end

    // The output side switches at random between several stall patterns.
    always @(posedge i_clk) begin
        if (stall_tick == 49) begin
            stall_tick <= 0;
            stall_mode <= $urandom_range(0, 3);
        end else begin
            stall_tick <= stall_tick + 1;
        end
        case (stall_mode)
            0:       i_m_tready <= 1'b1;
            1:       i_m_tready <= $urandom_range(0, 1);
            2:       i_m_tready <= ($urandom_range(0, 3) == 0);
            default: i_m_tready <= ((stall_tick % 7) < 3);
        endcase
    end

    task automatic apb_access(input bit write, input logic [APB_ADDR_BITS-1:0] addr,
                              input logic [APB_DATA_BITS-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_query(input logic [15:0] qx, input logic [15:0] qy,
                             input logic [3:0] k);
        logic [31:0] noise;
        noise = $urandom;
        apb_access(1'b1, {REG_QUERY_X, 2'b00}, {noise[31:16], qx});
        noise = $urandom;
        apb_access(1'b1, {REG_QUERY_Y, 2'b00}, {noise[31:16], qy});
        noise = $urandom;
        apb_access(1'b1, {REG_NEIGHBOR_COUNT, 2'b00}, {noise[31:4], k});
        apb_access(1'b0, {REG_QUERY_X, 2'b00}, '0);
        apb_access(1'b0, {REG_QUERY_Y, 2'b00}, '0);
        apb_access(1'b0, {REG_NEIGHBOR_COUNT, 2'b00}, '0);
    endtask

    task automatic send_candidate(input logic [15:0] px, input logic [15:0] py,
                                  input logic [19:0] idx, input bit last);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 16);
            if (gap > 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {4'h0, idx, py, px};
        i_s_tlast  <= last;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        burst_left--;
    endtask

    // Lets every expected neighbor arrive and the slot engine drain its queue.
    task automatic wait_idle();
        i_s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic logic [15:0] pick_coord(input logic [15:0] centre, input int mode);
        case (mode)
            0:       return 16'($urandom);
            1:       return centre + 16'($urandom_range(0, 16)) - 16'd8;
            2:       return ($urandom_range(0, 1) == 1) ? 16'h7FFF : 16'h8000;
            default: return centre + 16'($urandom_range(0, 512)) - 16'd256;
        endcase
    endfunction

    initial begin : stimulus
        logic [15:0] qx;
        logic [15:0] qy;
        logic [15:0] px;
        logic [15:0] py;
        logic [3:0]  k;
        int          sent;
        int          len;
        int          mode;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Default registers: one candidate leaves two slots empty.
        send_candidate(16'h7FFF, 16'h8000, 20'hFFFFF, 1'b1);
        wait_idle();

        // Opposite corners, ties, a full list and strictly closer replacements.
        set_query(16'h8000, 16'h7FFF, 4'd8);
        send_candidate(16'h7FFF, 16'h8000, 20'hFFFFF, 1'b0);
        send_candidate(16'h8000, 16'h7FFF, 20'h00001, 1'b0);
        send_candidate(16'h8001, 16'h7FFF, 20'h00002, 1'b0);
        send_candidate(16'h7FFF, 16'h7FFF, 20'h00003, 1'b0);
        send_candidate(16'h8000, 16'h8000, 20'h00004, 1'b0);
        send_candidate(16'h8002, 16'h7FFF, 20'h00005, 1'b0);
        send_candidate(16'h8000, 16'h7FFE, 20'h00006, 1'b0);
        send_candidate(16'h8003, 16'h7FFF, 20'h00007, 1'b0);
        send_candidate(16'h8001, 16'h7FFF, 20'h00008, 1'b0);
        send_candidate(16'h8003, 16'h7FFF, 20'h00009, 1'b1);
        wait_idle();

        // A count of zero acts as one, a count above the slot number as the maximum.
        set_query(16'h0000, 16'h0000, 4'd0);
        send_candidate(16'h0005, 16'h0005, 20'h00010, 1'b0);
        send_candidate(16'h0001, 16'hFFFF, 20'h00011, 1'b0);
        send_candidate(16'h0003, 16'h0000, 20'h00012, 1'b1);
        wait_idle();
        set_query(16'h1234, 16'hEDCB, 4'd15);
        send_candidate(16'h1234, 16'hEDCB, 20'h00020, 1'b0);
        send_candidate(16'h0000, 16'h0000, 20'h00021, 1'b0);
        send_candidate(16'hFFFF, 16'h0001, 20'h00022, 1'b0);
        send_candidate(16'h1235, 16'hEDCB, 20'h00023, 1'b1);
        wait_idle();

        // The count shrinks in the middle of a query; the upper slots must still be cleared.
        set_query(16'h0000, 16'h0000, 4'd8);
        for (int i = 0; i < 6; i++) begin
            send_candidate(16'(i * 3), 16'(i), 20'(16'h0100 + i), 1'b0);
        end
        wait_idle();
        apb_access(1'b1, {REG_NEIGHBOR_COUNT, 2'b00}, 32'd2);
        apb_access(1'b1, UNUSED_ADDR, 32'hFFFF_FFFF);
        send_candidate(16'h0001, 16'h0001, 20'h00200, 1'b1);
        wait_idle();
        apb_access(1'b1, {REG_NEIGHBOR_COUNT, 2'b00}, 32'd8);
        send_candidate(16'h4000, 16'hC000, 20'h00201, 1'b1);
        wait_idle();

        sent = 0;
        while (sent < RANDOM_PTS) begin
            case ($urandom_range(0, 5))
                0:       qx = 16'h8000;
                1:       qx = 16'h7FFF;
                default: qx = 16'($urandom);
            endcase
            qy = ($urandom_range(0, 5) == 0) ? 16'h8000 : 16'($urandom);
            k  = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(9, 15))
                                             : 4'($urandom_range(0, 8));
            set_query(qx, qy, k);
            repeat ($urandom_range(1, 4)) begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(12, 30)
                                                  : $urandom_range(1, 12);
                px = 16'($urandom);
                py = 16'($urandom);
                for (int i = 0; i < len; i++) begin
                    mode = $urandom_range(0, 5);
                    if (mode != 5) begin
                        px = pick_coord(qx, mode % 4);
                        py = pick_coord(qy, mode % 4);
                    end
                    send_candidate(px, py, 20'($urandom), i == len - 1);
                    sent++;
                end
            end
            wait_idle();
        end

        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("knn_distance_top_k_core_tb passed");
        end else begin
            $display("knn_distance_top_k_core_tb failed");
        end
        $finish;
    end

endmodule
